>>> rtl/smcn_pkg.sv
// Shared constants, command codes and controller/datapath bundles for the
// sensor min/max calibrate-and-normalize block. No dependencies.
package smcn_pkg;

    // Table size and field widths
    localparam int unsigned SENSOR_COUNT = 16;
    localparam int unsigned CNT_W        = 7;
    localparam int unsigned IDX_W        = 4;
    localparam int unsigned TABLE_DEPTH  = 1 << IDX_W;
    localparam int unsigned CMD_W        = 2;
    localparam int unsigned SAMPLE_W     = 12;
    localparam int unsigned SCALE_W      = 10;
    localparam int unsigned PROD_W       = SAMPLE_W + SCALE_W;
    localparam int unsigned STEP_W       = 4;

    localparam logic [CNT_W-1:0]    SENSOR_COUNT_V = CNT_W'(SENSOR_COUNT);
    localparam logic [SAMPLE_W-1:0] SAMPLE_TOP     = '1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ZERO    = '0;
    localparam logic [SCALE_W-1:0]  SCALE_TOP      = SCALE_W'(1000);
    localparam logic [STEP_W-1:0]   DIV_STEPS      = STEP_W'(SCALE_W);

    // Command codes carried in the input word
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CALIB = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NORM  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the input word
        logic prep;      // table update and operand setup
        logic mul;       // scale the offset and seed the divider
        logic step;      // one quotient bit
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_norm;   // captured word is a normalize request
        logic flat;      // empty or unusable window
        logic out_free;  // output register can take a word this cycle
    } t_dp_stat;

endpackage

>>> rtl/smcn_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on smcn_pkg for field widths.
interface smcn_in_if;
    logic                               valid;
    logic                               ready;
    logic [smcn_pkg::CMD_W-1:0]         cmd;
    logic [smcn_pkg::IDX_W-1:0]         sensor_index;
    logic [smcn_pkg::SAMPLE_W-1:0]      raw_sample;

    modport source (output valid, cmd, sensor_index, raw_sample, input ready);
    modport sink   (input valid, cmd, sensor_index, raw_sample, output ready);
endinterface

interface smcn_out_if;
    logic                               valid;
    logic                               ready;
    logic [smcn_pkg::SCALE_W-1:0]       scaled_value;
    logic                               flat_range;

    modport source (output valid, scaled_value, flat_range, input ready);
    modport sink   (input valid, scaled_value, flat_range, output ready);
endinterface

>>> rtl/smcn_dp.sv
// Datapath: calibration table, operand setup, scaling multiply, restoring
// divider and output register. Depends on smcn_pkg and smcn_out_if.
module smcn_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  smcn_pkg::t_dp_cmd              i_cmd,
    output smcn_pkg::t_dp_stat             o_stat,
    input  logic [smcn_pkg::CMD_W-1:0]     i_word_cmd,
    input  logic [smcn_pkg::IDX_W-1:0]     i_word_idx,
    input  logic [smcn_pkg::SAMPLE_W-1:0]  i_word_sample,
    smcn_out_if.source                     o_out
);

    // Captured input word
    logic [smcn_pkg::CMD_W-1:0]    r_cmd;
    logic [smcn_pkg::IDX_W-1:0]    r_idx;
    logic [smcn_pkg::SAMPLE_W-1:0] r_sample;

    // Calibration table; an entry without its valid bit reads as cleared
    logic [smcn_pkg::TABLE_DEPTH-1:0] r_valid;
    logic [smcn_pkg::SAMPLE_W-1:0]    r_low  [smcn_pkg::TABLE_DEPTH];
    logic [smcn_pkg::SAMPLE_W-1:0]    r_high [smcn_pkg::TABLE_DEPTH];

    // Operands and divider
    logic                          r_flat;
    logic [smcn_pkg::SAMPLE_W-1:0] r_diff;
    logic [smcn_pkg::SAMPLE_W-1:0] r_den;
    logic [smcn_pkg::SAMPLE_W-1:0] r_rem;
    logic [smcn_pkg::SCALE_W-1:0]  r_sh;

    // Output register
    logic                          r_out_valid;
    logic [smcn_pkg::SCALE_W-1:0]  r_out_scaled;
    logic                          r_out_flat;

    logic                          in_range;
    logic [smcn_pkg::SAMPLE_W-1:0] lo;
    logic [smcn_pkg::SAMPLE_W-1:0] hi;
    logic [smcn_pkg::SAMPLE_W-1:0] clamped;
    logic [smcn_pkg::PROD_W-1:0]   prod;
    logic [smcn_pkg::SAMPLE_W:0]   trial;
    logic [smcn_pkg::SAMPLE_W:0]   trial_sub;
    logic                          trial_ge;

    // Read the addressed entry
    assign in_range = {{(smcn_pkg::CNT_W - smcn_pkg::IDX_W){1'b0}}, r_idx}
                      < smcn_pkg::SENSOR_COUNT_V;
    assign lo = r_valid[r_idx] ? r_low[r_idx]  : smcn_pkg::SAMPLE_TOP;
    assign hi = r_valid[r_idx] ? r_high[r_idx] : smcn_pkg::SAMPLE_ZERO;

    // Clamp the sample into the window
    always_comb begin
        if (r_sample < lo) begin
            clamped = lo;
        end else if (r_sample > hi) begin
            clamped = hi;
        end else begin
            clamped = r_sample;
        end
    end

    assign prod = smcn_pkg::PROD_W'(r_diff) * smcn_pkg::PROD_W'(smcn_pkg::SCALE_TOP);

    // One restoring step: shift in the next numerator bit, subtract if it fits
    assign trial     = {r_rem, r_sh[smcn_pkg::SCALE_W-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign trial_ge  = trial >= {1'b0, r_den};

    // Capture the word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_word_cmd;
            r_idx    <= i_word_idx;
            r_sample <= i_word_sample;
        end
    end

    // Table valid bits: clear drops all, calibrate marks the entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.prep) begin
            if (r_cmd == smcn_pkg::CMD_CLEAR) begin
                r_valid <= '0;
            end else if (r_cmd == smcn_pkg::CMD_CALIB && in_range) begin
                r_valid[r_idx] <= 1'b1;
            end
        end
    end

    // Widen the window on calibrate
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep && r_cmd == smcn_pkg::CMD_CALIB && in_range) begin
            r_low[r_idx]  <= (r_sample < lo) ? r_sample : lo;
            r_high[r_idx] <= (r_sample > hi) ? r_sample : hi;
        end
    end

    // Operand setup, multiply and divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_flat <= !in_range || (hi <= lo);
            r_diff <= clamped - lo;
            r_den  <= hi - lo;
        end
        // Quotient stays below 1024, so the top numerator bits seed the remainder
        if (i_cmd.mul) begin
            r_rem <= prod[smcn_pkg::PROD_W-1:smcn_pkg::SCALE_W];
            r_sh  <= prod[smcn_pkg::SCALE_W-1:0];
        end else if (i_cmd.step) begin
            r_rem <= trial_ge ? trial_sub[smcn_pkg::SAMPLE_W-1:0]
                              : trial[smcn_pkg::SAMPLE_W-1:0];
            r_sh  <= {r_sh[smcn_pkg::SCALE_W-2:0], trial_ge};
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_scaled <= r_flat ? '0 : r_sh;
            r_out_flat   <= r_flat;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.scaled_value = r_out_scaled;
    assign o_out.flat_range   = r_out_flat;

    assign o_stat.is_norm  = (r_cmd == smcn_pkg::CMD_NORM);
    assign o_stat.flat     = r_flat;
    assign o_stat.out_free = !r_out_valid || o_out.ready;

endmodule

>>> rtl/smcn_ctrl.sv
// Controller: sequences capture, table update, multiply, divide steps and
// result hand-off. Depends on smcn_pkg.
module smcn_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smcn_pkg::t_dp_stat  i_stat,
    output smcn_pkg::t_dp_cmd   o_cmd,
    input  logic                i_in_valid,
    output logic                o_in_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [smcn_pkg::STEP_W-1:0] r_cnt;
    logic [smcn_pkg::STEP_W-1:0] n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and datapath commands
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd.load     = 1'b0;
        o_cmd.prep     = 1'b0;
        o_cmd.mul      = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_stat.is_norm ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = smcn_pkg::DIV_STEPS;
                n_state   = i_stat.flat ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == smcn_pkg::STEP_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the output register can take the word
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

>>> rtl/sensor_minmax_calibrate_normalize.sv
// Top level of the sensor min/max calibrate-and-normalize block.
// Depends on smcn_pkg, smcn_if, smcn_ctrl and smcn_dp.
//
//   channel  dir  fields                              word
//   i_in     in   cmd, sensor_index, raw_sample       one command
//   o_out    out  scaled_value, flat_range            one result per normalize
//
// Clear, calibrate and the unused command take 2 cycles from acceptance until
// the next word can be taken. Normalize takes 14 (capture, table read, multiply,
// 10 steps of the restoring divider, hand-off); the divider's one bit per cycle
// sets that. A flat normalize skips the divider and takes 4.
// A finished result sits in the output register while the next word enters.
// A stalled output holds a normalize in its hand-off cycle until the register frees.
// Synchronous active-low reset empties the table and the output register.
module sensor_minmax_calibrate_normalize (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smcn_in_if.sink     i_in,
    smcn_out_if.source  o_out
);

    smcn_pkg::t_dp_cmd  dp_cmd;
    smcn_pkg::t_dp_stat dp_stat;

    smcn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready)
    );

    smcn_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_word_cmd    (i_in.cmd),
        .i_word_idx    (i_in.sensor_index),
        .i_word_sample (i_in.raw_sample),
        .o_out         (o_out)
    );

endmodule
